// ----- hw/rtl/lrutc_pkg.sv -----
package lrutc_pkg;

    // Table geometry.
    localparam int WAYS     = 8;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Field widths of one input word and one result word.
    localparam int KEY_W    = 64;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 3;
    localparam int USE_W    = 32;

    // Stream bus widths.
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Item kinds.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    // One request as held in the input register.
    typedef struct packed {
        logic               kind;
        logic               key_empty;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] mod_stamp;
    } lrutc_req_t;

    // One result word.
    typedef struct packed {
        logic              no_entry;
        logic              evicted;
        logic              fill;
        logic              stale;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } lrutc_res_t;

endpackage

// ----- hw/rtl/lrutc_table.sv -----
module lrutc_table (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  lrutc_pkg::lrutc_req_t req,
    output lrutc_pkg::lrutc_res_t res
);

    localparam int LEAVES = 1 << lrutc_pkg::IDX_W;

    // Table state.
    logic [lrutc_pkg::WAYS-1:0]      entry_valid_reg;
    logic [lrutc_pkg::KEY_BITS-1:0]  entry_key_reg   [lrutc_pkg::WAYS];
    logic [lrutc_pkg::STAMP_W-1:0]   entry_stamp_reg [lrutc_pkg::WAYS];
    logic [lrutc_pkg::USE_W-1:0]     entry_use_reg   [lrutc_pkg::WAYS];
    logic [lrutc_pkg::USE_W-1:0]     use_clock_reg;
    logic [lrutc_pkg::USE_W-1:0]     use_clock_next;

    logic [lrutc_pkg::KEY_BITS-1:0]  key_cmp;
    logic [lrutc_pkg::WAYS-1:0]      match;
    logic [lrutc_pkg::WAYS-1:0]      stamp_diff;
    logic                            hit_any;
    logic                            free_any;
    logic                            stale;
    lrutc_pkg::idx_t                 hit_idx;
    lrutc_pkg::idx_t                 free_idx;
    lrutc_pkg::idx_t                 sel_idx;
    logic                            is_lookup;

    // Minimum-use tournament tree, heap ordered, leaves at LEAVES..2*LEAVES-1.
    logic [lrutc_pkg::USE_W-1:0]     node_use [2*LEAVES];
    lrutc_pkg::idx_t                 node_idx [2*LEAVES];
    logic                            node_ok  [2*LEAVES];

    assign key_cmp   = req.key[lrutc_pkg::KEY_BITS-1:0];
    assign is_lookup = (req.kind == lrutc_pkg::KIND_LOOKUP) && !req.key_empty;

    // Parallel tag compare against every valid entry.
    always_comb begin
        for (int i = 0; i < lrutc_pkg::WAYS; i++) begin
            match[i]      = entry_valid_reg[i] && (entry_key_reg[i] == key_cmp);
            stamp_diff[i] = entry_stamp_reg[i] != req.mod_stamp;
        end
    end

    assign hit_any  = |match;
    assign free_any = ~&entry_valid_reg;
    assign stale    = |(match & stamp_diff);

    // Lowest matching entry and lowest empty entry.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = lrutc_pkg::WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = lrutc_pkg::IDX_W'(i);
            end
            if (!entry_valid_reg[i]) begin
                free_idx = lrutc_pkg::IDX_W'(i);
            end
        end
    end

    // Oldest use stamp; the left (lower index) side wins a tie.
    always_comb begin
        for (int i = 0; i < 2 * LEAVES; i++) begin
            node_use[i] = '0;
            node_idx[i] = '0;
            node_ok[i]  = 1'b0;
        end
        for (int i = 0; i < LEAVES; i++) begin
            node_idx[LEAVES + i] = lrutc_pkg::IDX_W'(i);
            if (i < lrutc_pkg::WAYS) begin
                node_use[LEAVES + i] = entry_use_reg[i];
                node_ok[LEAVES + i]  = 1'b1;
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            if (node_ok[2*n+1] &&
                (!node_ok[2*n] || (node_use[2*n+1] < node_use[2*n]))) begin
                node_use[n] = node_use[2*n+1];
                node_idx[n] = node_idx[2*n+1];
                node_ok[n]  = 1'b1;
            end else begin
                node_use[n] = node_use[2*n];
                node_idx[n] = node_idx[2*n];
                node_ok[n]  = node_ok[2*n];
            end
        end
    end

    // Slot that serves the lookup.
    always_comb begin
        priority if (hit_any) begin
            sel_idx = hit_idx;
        end else if (free_any) begin
            sel_idx = free_idx;
        end else begin
            sel_idx = node_idx[1];
        end
    end

    assign use_clock_next = use_clock_reg + lrutc_pkg::USE_W'(1);

    // Result word.
    always_comb begin
        res = '0;
        if (is_lookup) begin
            res.slot    = lrutc_pkg::SLOT_W'(sel_idx);
            res.hit     = hit_any;
            res.stale   = hit_any && stale;
            res.fill    = !hit_any;
            res.evicted = !hit_any && !free_any;
        end else begin
            res.no_entry = 1'b1;
        end
    end

    // Valid bits, use stamps and the use clock.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            use_clock_reg   <= '0;
            for (int i = 0; i < lrutc_pkg::WAYS; i++) begin
                entry_use_reg[i] <= '0;
            end
        end else if (step) begin
            if (req.kind == lrutc_pkg::KIND_CLEAR) begin
                entry_valid_reg <= '0;
                for (int i = 0; i < lrutc_pkg::WAYS; i++) begin
                    entry_use_reg[i] <= '0;
                end
            end else if (!req.key_empty) begin
                use_clock_reg          <= use_clock_next;
                entry_use_reg[sel_idx] <= use_clock_next;
                entry_valid_reg[sel_idx] <= 1'b1;
            end
        end
    end

    // Tags and modification stamps; a hit rewrites the stamp with the new value.
    always_ff @(posedge aclk) begin
        if (step && is_lookup) begin
            entry_stamp_reg[sel_idx] <= req.mod_stamp;
            if (!hit_any) begin
                entry_key_reg[sel_idx] <= key_cmp;
            end
        end
    end

    // A lookup never reports both a hit and a fill.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(res.hit && res.fill))
        else $error("hit and fill reported together");

    // Eviction only happens when every entry was valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.evicted) |-> (&entry_valid_reg))
        else $error("eviction while an empty entry existed");

    // A served lookup advances the use clock by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && is_lookup) |=> (use_clock_reg == $past(use_clock_reg) + 32'd1))
        else $error("use clock did not advance by one");

    // A clear empties the table and keeps the use clock.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && req.kind == lrutc_pkg::KIND_CLEAR) |=>
            (entry_valid_reg == '0 && use_clock_reg == $past(use_clock_reg)))
        else $error("clear left valid entries or moved the use clock");

endmodule

// ----- hw/rtl/lru_tag_cache_with_stamp_check_top.sv -----
// An accepted word is held in the input register and reaches m_tdata through the result register.
// Throughput: one word per cycle unless back pressure on m_ stalls it; the tag compare, the
// oldest-entry tree and the table update all complete between the input and the result register.
// Back pressure on m_ stalls the input register, which then holds s_tready low.
// Reset (aresetn low, synchronous) empties the table, zeroes the use stamps and the use clock;
// there is no clearing pass, the block takes words right after reset.
module lru_tag_cache_with_stamp_check_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits from low: key[63:0], mod_stamp[95:64].
    input  logic [lrutc_pkg::S_TDATA_W-1:0]   s_tdata,
    // Bits from low: kind[0], key_empty[1].
    input  logic [lrutc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Bits from low: slot[2:0], hit[3], stale[4], fill[5], evicted[6], no_entry[7].
    output logic [lrutc_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    lrutc_pkg::lrutc_req_t in_req_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lrutc_pkg::lrutc_res_t out_res_reg;
    lrutc_pkg::lrutc_res_t res;
    logic                  out_free;
    logic                  step;
    logic                  s_take;

    // The result register can take a word when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_req_reg.kind      <= s_tuser[0];
            in_req_reg.key_empty <= s_tuser[1];
            in_req_reg.key       <= s_tdata[lrutc_pkg::KEY_W-1:0];
            in_req_reg.mod_stamp <= s_tdata[lrutc_pkg::KEY_W +: lrutc_pkg::STAMP_W];
        end
    end

    // Tag table with lookup and replacement.
    lrutc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (in_req_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_POOL   = 12;
    localparam int STAMP_POOL = 3;
    localparam int RAND_WORDS = 500;
    localparam int CYCLE_CAP  = 200000;

    // Tracks the cache contents and holds the results still due from the block.
    class lookup_checker;
        bit                          way_valid [lrutc_pkg::WAYS];
        bit [lrutc_pkg::KEY_W-1:0]   way_tag   [lrutc_pkg::WAYS];
        bit [lrutc_pkg::STAMP_W-1:0] way_stamp [lrutc_pkg::WAYS];
        bit [lrutc_pkg::USE_W-1:0]   way_age   [lrutc_pkg::WAYS];
        bit [lrutc_pkg::USE_W-1:0]   lru_clock;
        lrutc_pkg::lrutc_res_t       due_results [$];
        int                          errors;

        function new();
            foreach (way_valid[i]) begin
                way_valid[i] = 1'b0;
                way_age[i]   = '0;
            end
            lru_clock = '0;
            errors    = 0;
        endfunction

        // Apply one accepted word to the table and queue the result it must produce.
        function void note_word(lrutc_pkg::lrutc_req_t w);
            lrutc_pkg::lrutc_res_t res;
            int         free_way;
            int         way;
            bit         found;
            res      = '0;
            free_way = -1;
            way      = 0;
            found    = 1'b0;
            if (w.kind == lrutc_pkg::KIND_CLEAR) begin
                foreach (way_valid[i]) begin
                    way_valid[i] = 1'b0;
                    way_age[i]   = '0;
                end
                res.no_entry = 1'b1;
            end else if (w.key_empty) begin
                res.no_entry = 1'b1;
            end else begin
                for (int i = 0; i < lrutc_pkg::WAYS; i++) begin
                    if (found) begin
                        continue;
                    end
                    if (!way_valid[i]) begin
                        if (free_way < 0) free_way = i;
                    end else if (way_tag[i] == w.key) begin
                        found = 1'b1;
                        way   = i;
                    end
                end
                if (found) begin
                    res.hit   = 1'b1;
                    res.stale = (way_stamp[way] != w.mod_stamp);
                    way_stamp[way] = w.mod_stamp;
                end else begin
                    // Miss: first empty way, else the oldest one with ties to the lowest index.
                    if (free_way >= 0) begin
                        way = free_way;
                    end else begin
                        way = 0;
                        for (int i = 1; i < lrutc_pkg::WAYS; i++) begin
                            if (way_age[i] < way_age[way]) way = i;
                        end
                        res.evicted = 1'b1;
                    end
                    way_valid[way] = 1'b1;
                    way_tag[way]   = w.key;
                    way_stamp[way] = w.mod_stamp;
                    res.fill       = 1'b1;
                end
                lru_clock    = lru_clock + 1'b1;
                way_age[way] = lru_clock;
                res.slot     = way[lrutc_pkg::SLOT_W-1:0];
            end
            due_results.push_back(res);
        endfunction

        // Compare one result word with the oldest outstanding one.
        function void check_word(lrutc_pkg::lrutc_res_t got);
            lrutc_pkg::lrutc_res_t want;
            if (due_results.size() == 0) begin
                $error("result word 0x%02h arrived with nothing outstanding", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.stale !== want.stale) begin
                $error("stale: expected %0d, got %0d", want.stale, got.stale);
                errors++;
            end
            if (got.fill !== want.fill) begin
                $error("fill: expected %0d, got %0d", want.fill, got.fill);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.no_entry !== want.no_entry) begin
                $error("no_entry: expected %0d, got %0d", want.no_entry, got.no_entry);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lrutc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [lrutc_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lrutc_pkg::M_TDATA_W-1:0] m_tdata;

    lookup_checker  board = new();
    int             cycle_count = 0;
    int             burst_left = 0;
    bit             hold_off_go = 1'b0;
    bit [lrutc_pkg::KEY_W-1:0]   key_pool   [KEY_POOL];
    bit [lrutc_pkg::STAMP_W-1:0] stamp_pool [STAMP_POOL];

    lru_tag_cache_with_stamp_check_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_word(lrutc_pkg::lrutc_res_t'(m_tdata));
        end
    end

    // Receiver: phases of full rate, random stalls and toggling, plus one long hold-off.
    initial begin : receiver
        int  mode;
        int  span;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_go && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (120) @(posedge aclk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 2) != 0);
                    end
                    default: begin
                        m_tready <= ~m_tready;
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic lrutc_pkg::lrutc_req_t make_word(
        logic kind, logic key_empty,
        logic [lrutc_pkg::KEY_W-1:0] key,
        logic [lrutc_pkg::STAMP_W-1:0] mod_stamp);
        lrutc_pkg::lrutc_req_t w;
        w.kind      = kind;
        w.key_empty = key_empty;
        w.key       = key;
        w.mod_stamp = mod_stamp;
        return w;
    endfunction

    function automatic logic [lrutc_pkg::KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly lookups from a pool a bit larger than the table, so hits, stale
    // stamps and evictions all occur; the rest are clears, empty keys and noise.
    function automatic lrutc_pkg::lrutc_req_t random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            return make_word(lrutc_pkg::KIND_CLEAR, 1'($urandom_range(0, 1)),
                             random_key(), $urandom);
        end else if (pick < 8) begin
            return make_word(lrutc_pkg::KIND_LOOKUP, 1'b1, random_key(), $urandom);
        end else if (pick < 13) begin
            return make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, random_key(), $urandom);
        end
        return make_word(lrutc_pkg::KIND_LOOKUP, 1'b0,
                         key_pool[$urandom_range(0, KEY_POOL - 1)],
                         stamp_pool[$urandom_range(0, STAMP_POOL - 1)]);
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(input lrutc_pkg::lrutc_req_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= {w.mod_stamp, w.key};
        s_tuser  <= {w.key_empty, w.kind};
        do @(posedge aclk); while (!s_tready);
        board.note_word(w);
    endtask

    // Bursts of random length with random gaps in between.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_paced(input lrutc_pkg::lrutc_req_t w);
        pace();
        send_word(w);
    endtask

    initial begin : sender
        foreach (key_pool[i]) key_pool[i] = random_key();
        foreach (stamp_pool[i]) stamp_pool[i] = $urandom;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: key and stamp extremes, hits with same and new stamps,
        // an empty key that would hit, a full table with evictions, and clears.
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '0, '0));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '1, '1));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '0, '0));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '0, '1));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '1, '0));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b1, '0, '0));
        for (int i = 2; i < lrutc_pkg::WAYS; i++) begin
            send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, random_key(), $urandom));
        end
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, random_key(), $urandom));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '0, 32'h1));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '1, '0));
        send_paced(make_word(lrutc_pkg::KIND_CLEAR, 1'b0, random_key(), $urandom));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, '1, '1));
        send_paced(make_word(lrutc_pkg::KIND_CLEAR, 1'b1, '1, '1));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, {16{4'hA}}, {8{4'h5}}));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, {16{4'h5}}, {8{4'hA}}));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b0, {16{4'hA}}, {8{4'h5}}));
        send_paced(make_word(lrutc_pkg::KIND_LOOKUP, 1'b1, random_key(), $urandom));

        // Random traffic; the receiver takes its long hold-off early on.
        hold_off_go = 1'b1;
        repeat (RAND_WORDS) send_paced(random_word());
        s_tvalid <= 1'b0;

        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lrutc_pkg.sv
hw/rtl/lrutc_table.sv
hw/rtl/lru_tag_cache_with_stamp_check_top.sv
tb/sv/tb_top.sv
